// ===== design/scld_pkg.sv =====
`timescale 1ns / 1ps

package scld_pkg;

    localparam int LINE_LIMIT = 2048;
    localparam int LEN_W      = $clog2(LINE_LIMIT);

    localparam int DATA_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int PAT_COUNT  = 7;
    localparam int PAT_MAX    = 7;
    localparam int PAT_LOG    = 5;
    localparam int PAT_PERIOD = 6;
    localparam int PERIOD_PREFIX = 7;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [PAT_COUNT-1:0]  alive_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [DATA_W-1:0]     word_t;

    // Command codes on the result channel.
    localparam code_t CMD_UNKNOWN  = 4'd0;
    localparam code_t CMD_OFF      = 4'd1;
    localparam code_t CMD_STOP     = 4'd2;
    localparam code_t CMD_START    = 4'd3;
    localparam code_t CMD_SCALE_F  = 4'd4;
    localparam code_t CMD_SCALE_C  = 4'd5;
    localparam code_t CMD_LOG      = 4'd6;
    localparam code_t CMD_PERIOD   = 4'd7;
    localparam code_t CMD_TOO_LONG = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CELSIUS = 2'd1;

    localparam word_t START_PERIOD_RESET  = 32'd1;
    localparam logic  START_CELSIUS_RESET = 1'b0;

    // Number parser phases.
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_MINUS = 8'h2D;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;

    localparam logic [34:0] MAG_CAP = 35'h0_8000_0000;
    localparam word_t       POS_MAX = 32'h7FFF_FFFF;

    // Pattern text, padded with zero bytes past each pattern's length.
    localparam byte_t PAT_TEXT [PAT_COUNT][PAT_MAX] = '{
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "R", "T", 8'h00, 8'h00},
        '{"S", "C", "A", "L", "E", "=", "F"},
        '{"S", "C", "A", "L", "E", "=", "C"},
        '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "E", "R", "I", "O", "D", "="}
    };

    localparam logic [2:0] PAT_LEN [PAT_COUNT] = '{
        3'd3, 3'd4, 3'd5, 3'd7, 3'd7, 3'd3, 3'd7
    };

endpackage

// ===== design/sensor_command_line_decoder.sv =====
`timescale 1ns / 1ps

// Sensor command line decoder.
// Input channel (in_valid/in_ready, rx_byte) takes one received character per
// transaction. Lines end with a newline; each newline produces one result
// transaction on the output channel (out_valid/out_ready) carrying the command
// code and the active stopped flag, scale and period after the command.
// A stored byte beyond the line length limit produces a result with the
// too-long code and halts the block, as does the OFF command; a halted block
// accepts and drops every byte until reset.
// Throughput is one byte per cycle. A byte is held in the input register
// and its result is registered in the output register, which drives
// out_valid. The per-byte update of the match flags and the decimal
// accumulator is combinational logic.
// When the receiver stalls, the result holds and the input register keeps
// taking bytes that produce no result; a byte that would produce a second
// result waits until the output register frees.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready. Reset clears all line state; on the first cycle after reset
// the active period and scale load from the start registers.
module sensor_command_line_decoder
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [scld_pkg::BYTE_W-1:0]              rx_byte,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [scld_pkg::CODE_W-1:0]              command_code,
    output logic                                     stopped,
    output logic                                     celsius,
    output logic signed [scld_pkg::DATA_W-1:0]       period_value,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [scld_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [scld_pkg::DATA_W-1:0]              cfg_data
);
    import scld_pkg::*;

    word_t      start_period_reg;
    logic       start_celsius_reg;
    logic       init_reg;

    logic       a_valid_reg;
    byte_t      a_byte_reg;

    len_t       line_length_reg, line_length_next;
    alive_t     alive_reg, alive_next;
    logic [1:0] phase_reg, phase_next;
    logic       negative_reg, negative_next;
    word_t      magnitude_reg, magnitude_next;
    logic       stopped_reg, stopped_next;
    logic       celsius_reg, celsius_next;
    word_t      period_reg, period_next;
    logic       halted_reg, halted_next;

    logic       out_valid_reg;
    code_t      code_next;

    logic       emit;
    logic       fire;

    always_comb
    begin
        logic        digit;
        logic        found;
        logic [34:0] m;
        word_t       value;

        digit = 1'b0;
        found = 1'b0;
        m     = '0;
        value = '0;

        line_length_next = line_length_reg;
        alive_next       = alive_reg;
        phase_next       = phase_reg;
        negative_next    = negative_reg;
        magnitude_next   = magnitude_reg;
        stopped_next     = stopped_reg;
        celsius_next     = celsius_reg;
        period_next      = period_reg;
        halted_next      = halted_reg;
        code_next        = CMD_UNKNOWN;
        emit             = 1'b0;

        if (a_valid_reg && !halted_reg && a_byte_reg != '0 &&
            !(line_length_reg == '0 && (a_byte_reg == CH_SPACE || a_byte_reg == CH_TAB)))
        begin
            if (a_byte_reg != CH_LF)
            begin
                if (line_length_reg > len_t'(LINE_LIMIT - 2))
                begin
                    halted_next = 1'b1;
                    emit        = 1'b1;
                    code_next   = CMD_TOO_LONG;
                end
                else
                begin
                    for (int i = 0; i < PAT_COUNT; i++)
                    begin
                        if (line_length_reg < len_t'(PAT_LEN[i]))
                        begin
                            if (PAT_TEXT[i][line_length_reg[2:0]] != a_byte_reg)
                                alive_next[i] = 1'b0;
                        end
                        else if (i != PAT_LOG && i != PAT_PERIOD)
                        begin
                            alive_next[i] = 1'b0;
                        end
                    end

                    // The period value starts right after the PERIOD= prefix.
                    if (line_length_reg >= len_t'(PERIOD_PREFIX))
                    begin
                        digit = a_byte_reg >= CH_ZERO && a_byte_reg <= CH_NINE;
                        m = ({3'b000, magnitude_reg} << 3) + ({3'b000, magnitude_reg} << 1)
                            + {31'd0, a_byte_reg[3:0]};
                        case (phase_reg)
                            PH_SKIP:
                            begin
                                if (a_byte_reg == CH_SPACE ||
                                    (a_byte_reg >= CH_TAB && a_byte_reg <= CH_CR))
                                    phase_next = PH_SKIP;
                                else if (a_byte_reg == CH_PLUS || a_byte_reg == CH_MINUS)
                                begin
                                    negative_next = a_byte_reg == CH_MINUS;
                                    phase_next    = PH_SIGN;
                                end
                                else if (digit)
                                begin
                                    magnitude_next = (m > MAG_CAP) ? MAG_CAP[31:0] : m[31:0];
                                    phase_next     = PH_DIGITS;
                                end
                                else
                                    phase_next = PH_DONE;
                            end
                            PH_SIGN, PH_DIGITS:
                            begin
                                if (digit)
                                begin
                                    magnitude_next = (m > MAG_CAP) ? MAG_CAP[31:0] : m[31:0];
                                    phase_next     = PH_DIGITS;
                                end
                                else
                                    phase_next = PH_DONE;
                            end
                            default:
                                phase_next = PH_DONE;
                        endcase
                    end
                    line_length_next = line_length_reg + len_t'(1);
                end
            end
            else
            begin
                emit = 1'b1;
                for (int i = 0; i < 5; i++)
                begin
                    if (!found && alive_reg[i] && line_length_reg == len_t'(PAT_LEN[i]))
                    begin
                        found     = 1'b1;
                        code_next = code_t'(i + 1);
                    end
                end

                if (negative_reg)
                    value = '0 - magnitude_reg;
                else
                    value = (magnitude_reg > POS_MAX) ? POS_MAX : magnitude_reg;

                if (found)
                begin
                    case (code_next)
                        CMD_OFF:     halted_next  = 1'b1;
                        CMD_STOP:    stopped_next = 1'b1;
                        CMD_START:   stopped_next = 1'b0;
                        CMD_SCALE_F: celsius_next = 1'b0;
                        CMD_SCALE_C: celsius_next = 1'b1;
                        default:     ;
                    endcase
                end
                else if (alive_reg[PAT_LOG] && line_length_reg >= len_t'(3))
                    code_next = CMD_LOG;
                else if (alive_reg[PAT_PERIOD] && line_length_reg > len_t'(PERIOD_PREFIX))
                begin
                    code_next   = CMD_PERIOD;
                    period_next = value;
                end
                else
                    code_next = CMD_UNKNOWN;

                line_length_next = '0;
                alive_next       = '1;
                phase_next       = PH_SKIP;
                negative_next    = 1'b0;
                magnitude_next   = '0;
            end
        end
    end

    // A byte that produces no result never waits on the output register.
    assign fire      = a_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready  = !a_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_period_reg  <= START_PERIOD_RESET;
            start_celsius_reg <= START_CELSIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_START_PERIOD)
                start_period_reg <= cfg_data;
            else if (cfg_index == REG_START_CELSIUS)
                start_celsius_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg        <= 1'b1;
            a_valid_reg     <= 1'b0;
            line_length_reg <= '0;
            alive_reg       <= '1;
            phase_reg       <= PH_SKIP;
            negative_reg    <= 1'b0;
            magnitude_reg   <= '0;
            stopped_reg     <= 1'b0;
            celsius_reg     <= START_CELSIUS_RESET;
            period_reg      <= START_PERIOD_RESET;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;

            // No byte can be in the input register on the first cycle after reset.
            if (init_reg)
            begin
                init_reg    <= 1'b0;
                celsius_reg <= start_celsius_reg;
                period_reg  <= start_period_reg;
            end
            else if (fire)
            begin
                line_length_reg <= line_length_next;
                alive_reg       <= alive_next;
                phase_reg       <= phase_next;
                negative_reg    <= negative_next;
                magnitude_reg   <= magnitude_next;
                stopped_reg     <= stopped_next;
                celsius_reg     <= celsius_next;
                period_reg      <= period_next;
                halted_reg      <= halted_next;
            end

            if (fire && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            a_byte_reg <= rx_byte;
        if (fire && emit)
        begin
            command_code <= code_next;
            stopped      <= stopped_next;
            celsius      <= celsius_next;
            period_value <= period_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/scld_checker.sv =====
`timescale 1ns / 1ps

module scld_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [scld_pkg::CODE_W-1:0]        command_code,
    input logic                               stopped,
    input logic                               celsius,
    input logic signed [scld_pkg::DATA_W-1:0] period_value
);
    import scld_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_code) &&
        $stable(stopped) && $stable(celsius) && $stable(period_value))
        else $error("result changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> command_code <= CMD_TOO_LONG)
        else $error("command code out of range");

    // After OFF or the length error the block is halted and sends nothing more.
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready &&
        (command_code == CMD_OFF || command_code == CMD_TOO_LONG) |=> !out_valid)
        else $error("result after halt");

    a_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command_code == CMD_SCALE_C || command_code == CMD_SCALE_F)
        |-> celsius == (command_code == CMD_SCALE_C))
        else $error("scale does not follow scale command");

    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command_code == CMD_STOP || command_code == CMD_START)
        |-> stopped == (command_code == CMD_STOP))
        else $error("stopped flag does not follow command");

endmodule

bind sensor_command_line_decoder scld_checker u_scld_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command_code (command_code),
    .stopped      (stopped),
    .celsius      (celsius),
    .period_value (period_value)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import scld_pkg::*;

    localparam int RANDOM_BYTES   = 700;
    localparam int IDLE_PERCENT   = 27;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NO_GAP_FROM    = 250;
    localparam int NO_GAP_TO      = 450;

    // Indexes past the two start registers; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int SLOT_OFF     = 0;
    localparam int SLOT_STOP    = 1;
    localparam int SLOT_START   = 2;
    localparam int SLOT_SCALE_F = 3;
    localparam int SLOT_SCALE_C = 4;
    localparam int SLOT_LOG     = 5;
    localparam int SLOT_PERIOD  = 6;
    localparam int SLOT_COUNT   = 7;
    localparam int PREFIX_LEN   = 7;

    localparam byte_t CH_NUL    = 8'h00;
    localparam word_t MAG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        code_t cmd;
        logic  stop;
        logic  cels;
        word_t period;
    } line_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    byte_t                    rx_byte;
    logic                     out_valid;
    logic                     out_ready;
    code_t                    command_code;
    logic                     stopped;
    logic                     celsius;
    logic signed [DATA_W-1:0] period_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    word_t                    cfg_data;

    string cmd_text [SLOT_COUNT] = '{"OFF", "STOP", "START", "SCALE=F", "SCALE=C",
                                     "LOG", "PERIOD="};

    // Decoder state as predicted from the accepted bytes.
    len_t         cur_len;
    alive_t       cur_alive;
    logic [1:0]   num_phase;
    logic         num_neg;
    word_t        num_mag;
    logic         act_stopped;
    logic         act_celsius;
    word_t        act_period;
    logic         act_halted;
    word_t        shadow_start_period;
    logic         shadow_start_celsius;
    line_result_t expected_results[$];

    int    bytes_sent;
    int    results_seen;
    int    reg_writes;
    int    error_count;
    logic  no_gaps;
    logic  hold_request;
    string halt_reason;

    sensor_command_line_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_code (command_code),
        .stopped      (stopped),
        .celsius      (celsius),
        .period_value (period_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic clear_line_state();
        cur_len   = '0;
        cur_alive = '1;
        num_phase = PH_SKIP;
        num_neg   = 1'b0;
        num_mag   = '0;
    endtask

    task automatic predict_byte(byte_t ch);
        line_result_t res;
        logic [35:0]  grown;
        logic         take;
        int           hit;
        code_t        cmd;
        if (act_halted || ch == CH_NUL)
            return;
        if (cur_len == '0 && (ch == CH_SPACE || ch == CH_TAB))
            return;
        if (ch != CH_LF && cur_len > len_t'(LINE_LIMIT - 2))
        begin
            act_halted = 1'b1;
            res.cmd    = CMD_TOO_LONG;
            res.stop   = act_stopped;
            res.cels   = act_celsius;
            res.period = act_period;
            expected_results.push_back(res);
            return;
        end
        if (ch != CH_LF)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (cur_alive[i])
                begin
                    if (cur_len < cmd_text[i].len())
                    begin
                        if (cmd_text[i][cur_len] != ch)
                            cur_alive[i] = 1'b0;
                    end
                    else if (i != SLOT_LOG && i != SLOT_PERIOD)
                        cur_alive[i] = 1'b0;
                end
            end
            // The value after PERIOD= follows atoi: blanks, one sign, digits.
            if (cur_len >= PREFIX_LEN)
            begin
                take = 1'b0;
                if (num_phase == PH_SKIP)
                begin
                    if (ch == CH_PLUS || ch == CH_MINUS)
                    begin
                        num_neg   = (ch == CH_MINUS);
                        num_phase = PH_SIGN;
                    end
                    else if (!(ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)))
                    begin
                        num_phase = PH_SIGN;
                        take      = 1'b1;
                    end
                end
                else if (num_phase == PH_SIGN || num_phase == PH_DIGITS)
                    take = 1'b1;
                if (take)
                begin
                    if (ch >= CH_ZERO && ch <= CH_NINE)
                    begin
                        grown = {4'd0, num_mag} * 36'd10 + {28'd0, ch - CH_ZERO};
                        num_mag = (grown > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : grown[31:0];
                        num_phase = PH_DIGITS;
                    end
                    else
                        num_phase = PH_DONE;
                end
            end
            cur_len = cur_len + 1'b1;
            return;
        end
        hit = -1;
        for (int i = SLOT_SCALE_C; i >= SLOT_OFF; i--)
            if (cur_alive[i] && cur_len == cmd_text[i].len())
                hit = i;
        case (hit)
            SLOT_OFF:
            begin
                act_halted = 1'b1;
                cmd        = CMD_OFF;
            end
            SLOT_STOP:
            begin
                act_stopped = 1'b1;
                cmd         = CMD_STOP;
            end
            SLOT_START:
            begin
                act_stopped = 1'b0;
                cmd         = CMD_START;
            end
            SLOT_SCALE_F:
            begin
                act_celsius = 1'b0;
                cmd         = CMD_SCALE_F;
            end
            SLOT_SCALE_C:
            begin
                act_celsius = 1'b1;
                cmd         = CMD_SCALE_C;
            end
            default:
            begin
                if (cur_alive[SLOT_LOG] && cur_len >= cmd_text[SLOT_LOG].len())
                    cmd = CMD_LOG;
                else if (cur_alive[SLOT_PERIOD] && cur_len > PREFIX_LEN)
                begin
                    act_period = num_neg ? (32'd0 - num_mag)
                                         : ((num_mag > POS_MAX) ? POS_MAX : num_mag);
                    cmd = CMD_PERIOD;
                end
                else
                    cmd = CMD_UNKNOWN;
            end
        endcase
        clear_line_state();
        res.cmd    = cmd;
        res.stop   = act_stopped;
        res.cels   = act_celsius;
        res.period = act_period;
        expected_results.push_back(res);
    endtask

    task automatic send_byte(byte_t b);
        while (!no_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // Drops valid, then waits until every predicted result has come back and
    // the pipeline has had time to finish any byte that produces nothing.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
        while ($urandom_range(99) < IDLE_PERCENT)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // The active settings only load at reset, so a write changes the copy alone.
        if (idx == REG_START_PERIOD)
            shadow_start_period = val;
        else if (idx == REG_START_CELSIUS)
            shadow_start_celsius = val[0];
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic send_random_line();
        byte_t text[$];
        byte_t blank_set [5] = '{CH_SPACE, CH_TAB, 8'h0B, 8'h0C, CH_CR};
        string word;
        string limit_text;
        int    kind;
        int    n;
        int    pos;
        int    base;
        byte_t repl;
        kind = $urandom_range(99);
        if ($urandom_range(99) < 25)
        begin
            repeat ($urandom_range(3, 1))
            begin
                case ($urandom_range(2))
                    0: text.push_back(CH_SPACE);
                    1: text.push_back(CH_TAB);
                    default: text.push_back(CH_NUL);
                endcase
            end
        end
        base = text.size();
        if (kind < 12)
            word = cmd_text[SLOT_STOP];
        else if (kind < 24)
            word = cmd_text[SLOT_START];
        else if (kind < 32)
            word = cmd_text[SLOT_SCALE_F];
        else if (kind < 40)
            word = cmd_text[SLOT_SCALE_C];
        else if (kind < 50)
            word = cmd_text[SLOT_LOG];
        else if (kind < 75)
            word = cmd_text[SLOT_PERIOD];
        else if (kind < 88)
            word = cmd_text[$urandom_range(SLOT_COUNT - 1)];
        else
            word = "";
        foreach (word[i])
            text.push_back(word[i]);
        if (kind >= 40 && kind < 50)
        begin
            repeat ($urandom_range(4))
                text.push_back(byte_t'($urandom_range(8'h7E, 8'h21)));
        end
        else if (kind >= 50 && kind < 75)
        begin
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(2, 1))
                    text.push_back(blank_set[$urandom_range(4)]);
            if ($urandom_range(99) < 40)
                text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            case ($urandom_range(9))
                0: n = 0;
                1: n = $urandom_range(12, 10);
                2:
                begin
                    case ($urandom_range(3))
                        0: limit_text = "2147483647";
                        1: limit_text = "2147483648";
                        2: limit_text = "2147483649";
                        default: limit_text = "4294967296";
                    endcase
                    foreach (limit_text[i])
                        text.push_back(limit_text[i]);
                    n = 0;
                end
                default: n = $urandom_range(9, 1);
            endcase
            repeat (n)
                text.push_back(byte_t'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(99) < 15)
                text.push_back(byte_t'($urandom_range(8'h7A, 8'h61)));
        end
        else if (kind >= 75 && kind < 88)
        begin
            // Near misses: cut short, one extra character, or one character changed.
            case ($urandom_range(2))
                0: void'(text.pop_back());
                1: text.push_back(byte_t'($urandom_range(8'h7E, 8'h21)));
                default:
                begin
                    pos  = base + $urandom_range(word.len() - 1);
                    repl = byte_t'($urandom_range(255, 1));
                    if (repl == CH_LF)
                        repl = 8'h0B;
                    if (repl == text[pos])
                        repl = repl ^ 8'h20;
                    text[pos] = repl;
                end
            endcase
        end
        else if (kind >= 88)
        begin
            repeat ($urandom_range(10, 1))
                text.push_back(byte_t'($urandom_range(255)));
        end
        if ($urandom_range(99) < 10)
            text.insert($urandom_range(text.size()), CH_NUL);
        if ($urandom_range(99) < 5)
            text.push_back(CH_CR);
        text.push_back(CH_LF);
        foreach (text[i])
            send_byte(text[i]);
    endtask

    task automatic test_directed_commands();
        send_text("\n");
        send_byte(CH_NUL);
        send_text(" \t STOP\n");
        send_text("START\n");
        send_text("SCALE=C\n");
        send_text("SCALE=F\n");
        send_text("LOG\n");
        send_text("LOGXYZ\n");
        send_text("PERIOD=\n");
        send_text("PERIOD=x\n");
        send_text("PERIOD= \t-17\n");
        send_text("PERIOD=+2147483647\n");
        send_text("PERIOD=2147483648\n");
        send_text("PERIOD=-2147483648\n");
        send_text("PERIOD=-99999999999\n");
        send_text("PERIOD=12a34\n");
        send_text("PERIOD=+-5\n");
        send_text("ST");
        send_byte(CH_NUL);
        send_text("OP\n");
        send_text("OF\n");
        send_text("OFFX\n");
        send_text("stop\n");
        send_text("STOPS\n");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_text("\n");
        quiesce();
    endtask

    task automatic test_start_registers();
        word_t period_set [4];
        logic  scale_set [4];
        period_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, word_t'($urandom)};
        scale_set  = '{1'b1, 1'b0, 1'b1, 1'($urandom_range(1))};
        for (int k = 0; k < 4; k++)
        begin
            quiesce();
            write_reg(REG_START_PERIOD, period_set[k]);
            write_reg(REG_START_CELSIUS, word_t'(scale_set[k]));
            if (k == 2)
            begin
                write_reg(REG_SPARE_A, word_t'($urandom));
                write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
            end
            send_text("SCALE=F\n");
            repeat (4) send_random_line();
        end
        quiesce();
    endtask

    task automatic test_random_lines();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            no_gaps = (bytes_sent - first >= NO_GAP_FROM) && (bytes_sent - first < NO_GAP_TO);
            send_random_line();
        end
        no_gaps = 1'b0;
        quiesce();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        no_gaps      = 1'b1;
        repeat (20) send_random_line();
        no_gaps = 1'b0;
        quiesce();
    endtask

    task automatic test_halt_and_ignore();
        if ($urandom_range(1))
        begin
            halt_reason = "OFF command";
            send_text(" OFF\n");
        end
        else
        begin
            halt_reason = "line length error";
            repeat (LINE_LIMIT)
                send_byte(byte_t'($urandom_range(8'h7E, 8'h21)));
        end
        // Everything from here on is dropped without a result.
        send_text("STOP\nPERIOD=3\n");
        repeat (40)
            send_byte(byte_t'($urandom_range(255)));
        send_byte(CH_LF);
        quiesce();
    endtask

    initial
    begin : result_sink
        line_result_t want;
        int           hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result transaction, code %0d", $time,
                             command_code);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (command_code !== want.cmd)
                    begin
                        error_count++;
                        $display("%0t: command_code expected %0d actual %0d", $time,
                                 want.cmd, command_code);
                    end
                    if (stopped !== want.stop)
                    begin
                        error_count++;
                        $display("%0t: stopped expected %0d actual %0d", $time,
                                 want.stop, stopped);
                    end
                    if (celsius !== want.cels)
                    begin
                        error_count++;
                        $display("%0t: celsius expected %0d actual %0d", $time,
                                 want.cels, celsius);
                    end
                    if (period_value !== want.period)
                    begin
                        error_count++;
                        $display("%0t: period_value expected %0d actual %0d", $time,
                                 $signed(want.period), period_value);
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results still expected", $time,
                 WATCHDOG_LIMIT, expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        rx_byte      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        bytes_sent   = 0;
        results_seen = 0;
        reg_writes   = 0;
        error_count  = 0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        halt_reason  = "";
        shadow_start_period  = START_PERIOD_RESET;
        shadow_start_celsius = START_CELSIUS_RESET;
        act_stopped  = 1'b0;
        act_celsius  = shadow_start_celsius;
        act_period   = shadow_start_period;
        act_halted   = 1'b0;
        clear_line_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_directed_commands();
        test_start_registers();
        test_random_lines();
        test_output_backpressure();
        test_halt_and_ignore();

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d bytes sent, %0d results checked, %0d register writes",
                 bytes_sent, results_seen, reg_writes);
        $display("Summary: all commands, period parsing and a stalled receiver; halted by %s",
                 halt_reason);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
